[src/imf3_pkg.sv]
// imf3_pkg: shared types and constants of the 3x3 smoothing / high-pass filter.
// No dependencies; used by the channel interfaces, the kernel and the core.
`default_nettype none

package imf3_pkg;

   localparam int PIX_W     = 8;
   localparam int OUT_W     = 10;
   localparam int DIM_W     = 9;
   localparam int ROW_W     = 8;
   localparam int H_AW      = 10;
   localparam int WIN_N     = 9;
   localparam int APB_AW    = 4;
   localparam int APB_DW    = 32;
   localparam int REG_IDX_W = 2;

   localparam int MAX_HEIGHT = 256;
   localparam int MIN_DIM    = 3;

   localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

   localparam logic             MODE_SMOOTH          = 1'b0;
   localparam logic             RESET_FILTER_MODE    = MODE_SMOOTH;
   localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH    = 9'd200;
   localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT   = 9'd200;

   typedef logic [WIN_N-1:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic mode;
      logic border;
   } kernel_ctrl_type;

endpackage

`default_nettype wire

[src/imf3_chan_if.sv]
// imf3_req_if / imf3_rsp_if: valid/ready channels for pixel and result transactions.
// Depends on imf3_pkg for payload widths.
`default_nettype none

interface imf3_req_if;
   logic                       valid;
   logic                       ready;
   logic [imf3_pkg::PIX_W-1:0] pixel_in;
   logic                       bubble;

   modport source (output valid, output pixel_in, output bubble, input ready);
   modport sink   (input valid, input pixel_in, input bubble, output ready);
endinterface

interface imf3_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [imf3_pkg::OUT_W-1:0] pixel_out;
   logic                       last_out;

   modport source (output valid, output pixel_out, output last_out, input ready);
   modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

`default_nettype wire

[src/imf3_ram.sv]
// imf3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/imf3_kernel.sv]
// imf3_kernel: 3x3 smoothing / absolute high-pass arithmetic on one window.
// Depends on imf3_pkg (win_type, kernel_ctrl_type).
`default_nettype none

module imf3_kernel (
   input  wire imf3_pkg::win_type         win,
   input  wire imf3_pkg::kernel_ctrl_type ctrl,
   output logic [imf3_pkg::OUT_W-1:0]     pixel_out
);

   logic [9:0]  corners;
   logic [9:0]  edges;
   logic [11:0] smooth_sum;
   logic [11:0] hp_pos;
   logic [11:0] hp_neg;
   logic [11:0] hp_abs;

   always_comb begin
      corners    = 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
      edges      = 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
      smooth_sum = 12'(corners) + {1'b0, edges, 1'b0} + {2'b00, win[4], 2'b00};
      hp_pos     = {2'b00, win[4], 2'b00} + {1'b0, win[4], 3'b000};
      hp_neg     = {1'b0, edges, 1'b0} + 12'(corners);
      hp_abs     = (hp_pos >= hp_neg) ? (hp_pos - hp_neg) : (hp_neg - hp_pos);

      if (ctrl.border) begin
         pixel_out = imf3_pkg::OUT_W'(win[4]);
      end else if (ctrl.mode == imf3_pkg::MODE_SMOOTH) begin
         pixel_out = imf3_pkg::OUT_W'(smooth_sum[11:4]);
      end else begin
         pixel_out = hp_abs[11:2];
      end
   end

endmodule

`default_nettype wire

[src/image_3x3_smooth_highpass_filter_core.sv]
// Streaming 3x3 filter over raster-order 8-bit frames: smoothing (1-2-1 kernel, sum / 16) or
// absolute high-pass (centre 12, edges -2, corners -1, result / 4), border pixels unchanged.
// One pixel or bubble transaction is taken per clock while stage 1 can advance and the line
// stores are not being cleared; its result goes from the stage 1 register to the rsp register,
// and the result of a pixel belongs to the pixel frame_width+1 positions back, so the last
// frame_width+1 results of a frame leave on bubbles or on the first pixels of the next frame.
// Rate is set by one read of each line store per pixel. After reset req_chan.ready stays low
// while the line stores are cleared; CSR writes are taken during that time. Depends on
// imf3_pkg, imf3_chan_if, imf3_ram and imf3_kernel.
`default_nettype none

module image_3x3_smooth_highpass_filter_core #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   imf3_req_if.sink                          req_chan,
   imf3_rsp_if.source                        rsp_chan,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [imf3_pkg::APB_AW-1:0]  paddr,
   input  wire logic [imf3_pkg::APB_DW-1:0]  pwdata,
   output logic      [imf3_pkg::APB_DW-1:0]  prdata,
   output logic                              pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = COL_W + 1;
   localparam int AW    = COL_W + 2;
   localparam int PW    = imf3_pkg::PIX_W;
   localparam int HAW   = imf3_pkg::H_AW;

   typedef struct packed {
      logic          valid;
      logic          emits;
      logic          is_pix;
      logic          use_drain;
      logic          drain_mid;
      logic          border;
      logic          last;
      logic          fwd_hit;
      logic [PW-1:0] px;
      logic [PW-1:0] fwd_px;
   } stage_type;

   // configuration
   logic                       mode_ff;
   logic [imf3_pkg::DIM_W-1:0] fwidth_ff;
   logic [imf3_pkg::DIM_W-1:0] fheight_ff;
   logic                       csr_wr;
   logic [imf3_pkg::REG_IDX_W-1:0] csr_idx;

   // position tracking
   logic [COL_W-1:0]           in_col_ff,  in_col_in;
   logic [imf3_pkg::ROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]           out_col_ff, out_col_in;
   logic [imf3_pkg::ROW_W-1:0] out_row_ff, out_row_in;
   logic [CNT_W-1:0]           pend_ff,    pend_in;

   // line store clearing
   logic                       clr_busy_ff;
   logic [COL_W-1:0]           clr_addr_ff;

   // pipeline
   stage_type                  s1_ff, s1_in;
   logic [COL_W-1:0]           s1_col_ff;
   imf3_pkg::win_type          win_ff, win_in;
   logic                       rsp_valid_ff;
   logic [imf3_pkg::OUT_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                       rsp_last_ff;

   logic [31:0]      fw32, w32;
   logic [AW-1:0]    w_a;
   logic [HAW-1:0]   h_a;
   logic [AW-1:0]    in_col_a, out_col_a, pend_a, owed;
   logic [HAW-1:0]   in_row_a, out_row_a;
   logic             pos_ge, old_pos, is_pix, emits;
   logic             req_acc, out_free, s1_adv, s1_wr;
   logic [AW-1:0]    in_col_inc, out_col_inc;
   logic [HAW-1:0]   in_row_inc, out_row_inc;

   logic             ram_wr_en;
   logic [COL_W-1:0] ram_wr_addr;
   logic [PW-1:0]    up_wr_data, mid_wr_data;
   logic [PW-1:0]    up_rd, mid_rd, cp_rd;
   logic [PW-1:0]    drain_val;
   logic [imf3_pkg::OUT_W-1:0] kern_out;
   imf3_pkg::kernel_ctrl_type  kern_ctrl;

   // ---------------- CSR port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[imf3_pkg::REG_IDX_W+1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= imf3_pkg::RESET_FILTER_MODE;
         fwidth_ff  <= imf3_pkg::RESET_FRAME_WIDTH;
         fheight_ff <= imf3_pkg::RESET_FRAME_HEIGHT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            imf3_pkg::REG_FILTER_MODE:  mode_ff    <= pwdata[0];
            imf3_pkg::REG_FRAME_WIDTH:  fwidth_ff  <= pwdata[imf3_pkg::DIM_W-1:0];
            imf3_pkg::REG_FRAME_HEIGHT: fheight_ff <= pwdata[imf3_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         imf3_pkg::REG_FILTER_MODE:  prdata = imf3_pkg::APB_DW'(mode_ff);
         imf3_pkg::REG_FRAME_WIDTH:  prdata = imf3_pkg::APB_DW'(fwidth_ff);
         imf3_pkg::REG_FRAME_HEIGHT: prdata = imf3_pkg::APB_DW'(fheight_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------- frame size, clamped ----------------
   always_comb begin
      fw32 = 32'(fwidth_ff);
      priority if (fw32 < 32'(imf3_pkg::MIN_DIM)) begin
         w32 = 32'(imf3_pkg::MIN_DIM);
      end else if (fw32 > 32'(MAX_WIDTH)) begin
         w32 = 32'(MAX_WIDTH);
      end else begin
         w32 = fw32;
      end
      w_a = w32[AW-1:0];

      priority if (fheight_ff < imf3_pkg::DIM_W'(imf3_pkg::MIN_DIM)) begin
         h_a = HAW'(imf3_pkg::MIN_DIM);
      end else if (fheight_ff > imf3_pkg::DIM_W'(imf3_pkg::MAX_HEIGHT)) begin
         h_a = HAW'(imf3_pkg::MAX_HEIGHT);
      end else begin
         h_a = HAW'(fheight_ff);
      end
   end

   // ---------------- handshake ----------------
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv   = s1_ff.valid && (!s1_ff.emits || out_free);
   assign s1_wr    = s1_adv && s1_ff.is_pix;
   assign req_chan.ready = !clr_busy_ff && (!s1_ff.valid || s1_adv);
   assign req_acc  = req_chan.valid && req_chan.ready;

   // ---------------- entry decisions ----------------
   always_comb begin
      in_col_a  = AW'(in_col_ff);
      out_col_a = AW'(out_col_ff);
      pend_a    = AW'(pend_ff);
      in_row_a  = HAW'(in_row_ff);
      out_row_a = HAW'(out_row_ff);
      is_pix    = !req_chan.bubble;

      // outputs owed to the frame in progress, min(position, width+1)
      priority if (in_row_ff == '0) begin
         pos_ge = in_col_a >= w_a + AW'(1);
         owed   = pos_ge ? w_a + AW'(1) : in_col_a;
      end else if (in_row_ff == imf3_pkg::ROW_W'(1)) begin
         pos_ge = in_col_ff != '0;
         owed   = pos_ge ? w_a + AW'(1) : w_a;
      end else begin
         pos_ge = 1'b1;
         owed   = w_a + AW'(1);
      end
      old_pos = pend_a > owed;
      emits   = old_pos || (is_pix && pos_ge);

      s1_in.valid     = 1'b1;
      s1_in.emits     = emits;
      s1_in.is_pix    = is_pix;
      s1_in.use_drain = old_pos;
      s1_in.drain_mid = (out_row_a + HAW'(1)) >= h_a;
      s1_in.border    = (out_row_ff == '0) || (out_row_a + HAW'(2) > h_a) ||
                        (out_col_ff == '0) || (out_col_a + AW'(2) > w_a);
      s1_in.last      = (out_row_a + HAW'(1) == h_a) && (out_col_a + AW'(1) == w_a);
      s1_in.fwd_hit   = s1_wr && (s1_col_ff == out_col_ff);
      s1_in.px        = req_chan.pixel_in;
      s1_in.fwd_px    = s1_ff.px;

      pend_in = pend_ff + CNT_W'(is_pix) - CNT_W'(emits);

      in_col_inc = in_col_a + AW'(1);
      in_row_inc = in_row_a + HAW'(1);
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      if (is_pix) begin
         if (in_col_inc >= w_a) begin
            in_col_in = '0;
            in_row_in = (in_row_inc >= h_a) ? '0 : in_row_inc[imf3_pkg::ROW_W-1:0];
         end else begin
            in_col_in = in_col_inc[COL_W-1:0];
         end
      end

      out_col_inc = out_col_a + AW'(1);
      out_row_inc = out_row_a + HAW'(1);
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      if (emits) begin
         if (out_col_inc >= w_a) begin
            out_col_in = '0;
            out_row_in = (out_row_inc >= h_a) ? '0 : out_row_inc[imf3_pkg::ROW_W-1:0];
         end else begin
            out_col_in = out_col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else if (req_acc) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end

   // ---------------- line stores ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + COL_W'(1);
      end
   end

   assign ram_wr_en   = clr_busy_ff || s1_wr;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : s1_col_ff;
   assign up_wr_data  = clr_busy_ff ? '0 : mid_rd;
   assign mid_wr_data = clr_busy_ff ? '0 : s1_ff.px;

   imf3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (up_wr_data),
      .rd_en   (req_acc),
      .rd_addr (in_col_ff),
      .rd_data (up_rd)
   );

   imf3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (mid_wr_data),
      .rd_en   (req_acc),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   // copy of the middle store, read at the output column for draining the last row
   imf3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle_cp (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (mid_wr_data),
      .rd_en   (req_acc),
      .rd_addr (out_col_ff),
      .rd_data (cp_rd)
   );

   // ---------------- stage 1: window, kernel, result ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (req_acc) begin
         s1_ff <= s1_in;
      end else if (s1_adv) begin
         s1_ff.valid <= 1'b0;
      end
      if (req_acc) begin
         s1_col_ff <= in_col_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = up_rd;
      win_in[5] = mid_rd;
      win_in[8] = s1_ff.px;

      if (s1_ff.drain_mid) begin
         drain_val = s1_ff.fwd_hit ? s1_ff.fwd_px : cp_rd;
      end else begin
         drain_val = win_ff[5];
      end
      rsp_pixel_in = s1_ff.use_drain ? imf3_pkg::OUT_W'(drain_val) : kern_out;
   end

   assign kern_ctrl.mode   = mode_ff;
   assign kern_ctrl.border = s1_ff.border;

   imf3_kernel u_kernel (
      .win       (win_in),
      .ctrl      (kern_ctrl),
      .pixel_out (kern_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_wr) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_ff.emits) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv && s1_ff.emits) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_last_ff  <= s1_ff.last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pixel_ff;
   assign rsp_chan.last_out  = rsp_last_ff;

   // ---------------- checks ----------------
   a_no_store_collision: assert property (@(posedge clock) disable iff (reset)
      (req_acc && s1_wr) |-> (in_col_ff != s1_col_ff))
      else $error("line store read and write hit the same column");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.emits && rsp_valid_ff && !rsp_chan.ready) |=> $stable(s1_ff))
      else $error("stage 1 transaction lost while result stalled");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (pend_ff <= CNT_W'(MAX_WIDTH + 1)))
      else $error("owed result count out of range");

   a_clear_length: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> ($past(clr_addr_ff) == COL_W'(MAX_WIDTH - 1)))
      else $error("line store clearing ended early");

endmodule

`default_nettype wire
